// File: design/cpp_pkg.sv
// ----------------------------------------------------------------------------
// cpp_pkg: shared definitions for the camera point projection pipeline
// Register indexes, datapath widths, the divider stage record and rounding.
// ----------------------------------------------------------------------------
package cpp_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    IDX_ROT_ROW0   = 3'd0,
    IDX_ROT_ROW1   = 3'd1,
    IDX_ROT_ROW2   = 3'd2,
    IDX_TRANS_XY   = 3'd3,
    IDX_TRANS_Z    = 3'd4,
    IDX_INTRINSICS = 3'd5,
    IDX_DISTORTION = 3'd6
  } cfg_idx_e;

  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned CamW      = 52;  // camera space, 32 fraction bits
  localparam int unsigned NormFrac  = 24;
  localparam int unsigned DivSteps  = 27;  // 2 integer + 25 fraction bits
  localparam int unsigned RemW      = 54;
  localparam int unsigned DenW      = 52;  // twice the depth
  localparam int unsigned RndW      = 66;
  localparam int unsigned Latency   = 3 + DivSteps + 14;

  // One stage of the restoring divider, shared denominator for both axes.
  typedef struct packed {
    logic                 behind;
    logic                 clip_x;
    logic                 clip_y;
    logic                 neg_x;
    logic                 neg_y;
    logic [RemW-1:0]      rem_x;
    logic [RemW-1:0]      rem_y;
    logic [DenW-1:0]      den2;
    logic [DivSteps-1:0]  quo_x;
    logic [DivSteps-1:0]  quo_y;
  } div_t;

  // Arithmetic shift right by sh, rounding half away from zero.
  function automatic logic signed [RndW-1:0] rnd_haz(input logic signed [RndW-1:0] v,
                                                     input int unsigned sh);
    logic [RndW-1:0] half;
    logic [RndW-1:0] mag;
    half = RndW'(1) << (sh - 1);
    if (v < 0) begin
      mag = RndW'(-v);
      mag = (mag + half) >> sh;
      return -$signed(mag);
    end else begin
      mag = RndW'(v);
      mag = (mag + half) >> sh;
      return $signed(mag);
    end
  endfunction

endpackage

// File: design/camera_point_projection.sv
// ----------------------------------------------------------------------------
// camera_point_projection: pinhole projection with lens distortion
// Rotates and translates a world point, divides by depth, applies radial and
// tangential distortion and maps the result to pixel coordinates in Q16.16.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while the result is not stalled; the 27
// stage restoring divider and the split multipliers are fully pipelined.
// A stalled result freezes the whole pipeline; no item is lost or repeated.
// Reset clears all configuration registers and every pipeline valid bit.
module camera_point_projection (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [cpp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [cpp_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [31:0]           world_x_i,
  input  logic signed [31:0]           world_y_i,
  input  logic signed [31:0]           world_z_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [31:0]           pixel_u_o,
  output logic signed [31:0]           pixel_v_o,
  output logic                         behind_camera_o,
  output logic                         saturated_o
);
  import cpp_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers. Writes must only happen while the pipeline is
  // empty; the block does not enforce it. Stages read them without copies.
  // --------------------------------------------------------------------------
  logic [53:0] rot_q [3];
  logic [63:0] trans_xy_q;
  logic [31:0] trans_z_q;
  logic [63:0] intr_q;
  logic [63:0] dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q[0]   <= '0;
      rot_q[1]   <= '0;
      rot_q[2]   <= '0;
      trans_xy_q <= '0;
      trans_z_q  <= '0;
      intr_q     <= '0;
      dist_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        IDX_ROT_ROW0:   rot_q[0]   <= cfg_data_i[53:0];
        IDX_ROT_ROW1:   rot_q[1]   <= cfg_data_i[53:0];
        IDX_ROT_ROW2:   rot_q[2]   <= cfg_data_i[53:0];
        IDX_TRANS_XY:   trans_xy_q <= cfg_data_i;
        IDX_TRANS_Z:    trans_z_q  <= cfg_data_i[31:0];
        IDX_INTRINSICS: intr_q     <= cfg_data_i;
        IDX_DISTORTION: dist_q     <= cfg_data_i;
        default: ;  // Unknown indexes are ignored.
      endcase
    end
  end

  logic signed [15:0] k1, k2, p1, p2;
  logic        [15:0] fx, fy, px, py;
  assign fx = intr_q[15:0];
  assign fy = intr_q[31:16];
  assign px = intr_q[47:32];
  assign py = intr_q[63:48];
  assign k1 = $signed(dist_q[15:0]);
  assign k2 = $signed(dist_q[31:16]);
  assign p1 = $signed(dist_q[47:32]);
  assign p2 = $signed(dist_q[63:48]);

  // --------------------------------------------------------------------------
  // Handshake. All stages advance together; the pipeline holds only when the
  // last stage has a result that the consumer is not taking.
  // --------------------------------------------------------------------------
  logic [Latency-1:0] vld_q;
  logic               en;

  assign en          = !(vld_q[Latency-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[Latency-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Latency-2:0], in_valid_i};
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: the nine rotation products.
  // --------------------------------------------------------------------------
  logic signed [49:0] rp_q [3][3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        rp_q[a][0] <= $signed(rot_q[a][17:0])  * world_x_i;
        rp_q[a][1] <= $signed(rot_q[a][35:18]) * world_y_i;
        rp_q[a][2] <= $signed(rot_q[a][53:36]) * world_z_i;
      end
    end
  end

  // Stage 2: camera space sums, translation aligned to 32 fraction bits.
  logic signed [CamW-1:0] cx_q, cy_q, cz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cx_q <= CamW'(rp_q[0][0]) + CamW'(rp_q[0][1]) + CamW'(rp_q[0][2])
            + (CamW'($signed(trans_xy_q[31:0])) <<< 12);
      cy_q <= CamW'(rp_q[1][0]) + CamW'(rp_q[1][1]) + CamW'(rp_q[1][2])
            + (CamW'($signed(trans_xy_q[63:32])) <<< 12);
      cz_q <= CamW'(rp_q[2][0]) + CamW'(rp_q[2][1]) + CamW'(rp_q[2][2])
            + (CamW'($signed(trans_z_q)) <<< 12);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3 and the divider: magnitudes over the depth, one quotient bit per
  // stage. The remainder is compared against twice the depth and shifted,
  // which gives two integer and twenty-five fraction bits.
  // --------------------------------------------------------------------------
  logic [CamW-1:0] ax, ay;
  logic [CamW-2:0] dep;
  div_t            div_in;
  div_t            div_q [DivSteps+1];
  div_t            div_d [DivSteps];

  assign ax  = cx_q[CamW-1] ? CamW'(-cx_q) : CamW'(cx_q);
  assign ay  = cy_q[CamW-1] ? CamW'(-cy_q) : CamW'(cy_q);
  assign dep = cz_q[CamW-2:0];

  always_comb begin
    div_in        = '0;
    div_in.behind = cz_q[CamW-1] || (cz_q == '0);
    div_in.neg_x  = cx_q[CamW-1];
    div_in.neg_y  = cy_q[CamW-1];
    div_in.rem_x  = RemW'(ax);
    div_in.rem_y  = RemW'(ay);
    div_in.den2   = {dep, 1'b0};
    // A quotient of four or more is clamped.
    div_in.clip_x = RemW'(ax) >= RemW'({dep, 2'b00});
    div_in.clip_y = RemW'(ay) >= RemW'({dep, 2'b00});
  end

  always_comb begin
    logic [RemW-1:0] rx, ry;
    logic            gx, gy;
    for (int s = 0; s < DivSteps; s++) begin
      div_d[s] = div_q[s];
      gx = div_q[s].rem_x >= RemW'(div_q[s].den2);
      gy = div_q[s].rem_y >= RemW'(div_q[s].den2);
      rx = gx ? div_q[s].rem_x - RemW'(div_q[s].den2) : div_q[s].rem_x;
      ry = gy ? div_q[s].rem_y - RemW'(div_q[s].den2) : div_q[s].rem_y;
      div_d[s].rem_x = {rx[RemW-2:0], 1'b0};
      div_d[s].rem_y = {ry[RemW-2:0], 1'b0};
      div_d[s].quo_x = {div_q[s].quo_x[DivSteps-2:0], gx};
      div_d[s].quo_y = {div_q[s].quo_y[DivSteps-2:0], gy};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      div_q[0] <= div_in;
      for (int s = 0; s < DivSteps; s++) begin
        div_q[s+1] <= div_d[s];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Normalized coordinates in Q.24, rounded, with the wide angle clamp.
  // --------------------------------------------------------------------------
  div_t               dv;
  logic [DivSteps-1:0] resx, resy;
  logic [DivSteps:0]   sumx, sumy;

  assign dv   = div_q[DivSteps];
  assign sumx = {1'b0, dv.quo_x} + (DivSteps+1)'(1);
  assign sumy = {1'b0, dv.quo_y} + (DivSteps+1)'(1);
  assign resx = dv.clip_x ? DivSteps'(1) << (DivSteps-1) : sumx[DivSteps:1];
  assign resy = dv.clip_y ? DivSteps'(1) << (DivSteps-1) : sumy[DivSteps:1];

  // Per-stage registers, numbered after the divider.
  logic signed [27:0] xn_q [8];   // xn carried from P1 to P8
  logic signed [27:0] yn_q [8];
  logic               beh_q [13];
  logic               clp_q [13];

  always_ff @(posedge clk_i) begin
    if (en) begin
      xn_q[0]  <= dv.neg_x ? -$signed({1'b0, resx}) : $signed({1'b0, resx});
      yn_q[0]  <= dv.neg_y ? -$signed({1'b0, resy}) : $signed({1'b0, resy});
      beh_q[0] <= dv.behind;
      clp_q[0] <= dv.clip_x || dv.clip_y;
      for (int i = 1; i < 8; i++) begin
        xn_q[i] <= xn_q[i-1];
        yn_q[i] <= yn_q[i-1];
      end
      for (int i = 1; i < 13; i++) begin
        beh_q[i] <= beh_q[i-1];
        clp_q[i] <= clp_q[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Distortion polynomial.
  // --------------------------------------------------------------------------
  logic signed [55:0] x2p_q, y2p_q, xyp_q;            // P2
  logic signed [29:0] x2_q, y2_q, xy3_q;              // P3
  logic signed [30:0] r2_q;                           // P4
  logic signed [31:0] tx_q, ty_q;
  logic signed [29:0] xy4_q;
  logic signed [61:0] r2sq_q;                         // P5
  logic signed [46:0] k1r2_q;
  logic signed [45:0] p1xy_q, p2xy_q;
  logic signed [47:0] p2tx_q, p1ty_q;
  logic signed [35:0] r4_q;                           // P6
  logic signed [33:0] k1t_q [2];                      // P6, P7
  logic signed [30:0] p1xyt_q [5], p2xyt_q [5];       // P6..P10
  logic signed [32:0] p2txt_q [5], p1tyt_q [5];
  logic signed [51:0] k2r4_q;                         // P7
  logic signed [37:0] rad_q;                          // P8
  logic signed [47:0] mxlo_q, mylo_q;                 // P9
  logic signed [46:0] mxhi_q, myhi_q;
  logic signed [RndW-1:0] prx_q, pry_q;               // P10
  logic signed [41:0] xd_q, yd_q;                     // P11
  logic signed [38:0] ulo_q, vlo_q;                   // P12
  logic signed [37:0] uhi_q, vhi_q;
  logic signed [58:0] us_q, vs_q;                     // P13

  always_ff @(posedge clk_i) begin
    if (en) begin
      // P2: squares and cross product.
      x2p_q <= xn_q[0] * xn_q[0];
      y2p_q <= yn_q[0] * yn_q[0];
      xyp_q <= xn_q[0] * yn_q[0];
      // P3: back to Q.24.
      x2_q  <= 30'(rnd_haz(RndW'(x2p_q), NormFrac));
      y2_q  <= 30'(rnd_haz(RndW'(y2p_q), NormFrac));
      xy3_q <= 30'(rnd_haz(RndW'(xyp_q), NormFrac));
      // P4: radius squared and the tangential terms r2 + 2*x2, r2 + 2*y2.
      r2_q  <= 31'(x2_q) + 31'(y2_q);
      tx_q  <= 32'(x2_q) + (32'(x2_q) <<< 1) + 32'(y2_q);
      ty_q  <= 32'(y2_q) + (32'(y2_q) <<< 1) + 32'(x2_q);
      xy4_q <= xy3_q;
      // P5: coefficient products.
      r2sq_q <= r2_q * r2_q;
      k1r2_q <= k1 * r2_q;
      p1xy_q <= p1 * xy4_q;
      p2xy_q <= p2 * xy4_q;
      p2tx_q <= p2 * tx_q;
      p1ty_q <= p1 * ty_q;
      // P6: rounding.
      r4_q       <= 36'(rnd_haz(RndW'(r2sq_q), NormFrac));
      k1t_q[0]   <= 34'(rnd_haz(RndW'(k1r2_q), 14));
      p1xyt_q[0] <= 31'(rnd_haz(RndW'(p1xy_q), 14));
      p2xyt_q[0] <= 31'(rnd_haz(RndW'(p2xy_q), 14));
      p2txt_q[0] <= 33'(rnd_haz(RndW'(p2tx_q), 14));
      p1tyt_q[0] <= 33'(rnd_haz(RndW'(p1ty_q), 14));
      for (int i = 1; i < 5; i++) begin
        p1xyt_q[i] <= p1xyt_q[i-1];
        p2xyt_q[i] <= p2xyt_q[i-1];
        p2txt_q[i] <= p2txt_q[i-1];
        p1tyt_q[i] <= p1tyt_q[i-1];
      end
      // P7: second radial term.
      k2r4_q   <= k2 * r4_q;
      k1t_q[1] <= k1t_q[0];
      // P8: radial factor, one in Q.24.
      rad_q <= (38'sd1 <<< NormFrac) + 38'(k1t_q[1])
             + 38'(rnd_haz(RndW'(k2r4_q), 14));
      // P9: coordinate times radial factor, split in two partial products.
      mxlo_q <= xn_q[7] * $signed({1'b0, rad_q[18:0]});
      mylo_q <= yn_q[7] * $signed({1'b0, rad_q[18:0]});
      mxhi_q <= xn_q[7] * $signed(rad_q[37:19]);
      myhi_q <= yn_q[7] * $signed(rad_q[37:19]);
      // P10: combine the partial products.
      prx_q <= (RndW'(mxhi_q) <<< 19) + RndW'(mxlo_q);
      pry_q <= (RndW'(myhi_q) <<< 19) + RndW'(mylo_q);
      // P11: distorted coordinates.
      xd_q <= 42'(rnd_haz(prx_q, NormFrac)) + (42'(p1xyt_q[4]) <<< 1)
            + 42'(p2txt_q[4]);
      yd_q <= 42'(rnd_haz(pry_q, NormFrac)) + 42'(p1tyt_q[4])
            + (42'(p2xyt_q[4]) <<< 1);
      // P12: focal scaling, split in two partial products.
      ulo_q <= $signed({1'b0, fx}) * $signed({1'b0, xd_q[20:0]});
      vlo_q <= $signed({1'b0, fy}) * $signed({1'b0, yd_q[20:0]});
      uhi_q <= $signed({1'b0, fx}) * $signed(xd_q[41:21]);
      vhi_q <= $signed({1'b0, fy}) * $signed(yd_q[41:21]);
      // P13: add the principal point, 28 fraction bits.
      us_q <= (59'(uhi_q) <<< 21) + 59'(ulo_q)
            + (59'($signed({1'b0, px})) <<< NormFrac);
      vs_q <= (59'(vhi_q) <<< 21) + 59'(vlo_q)
            + (59'($signed({1'b0, py})) <<< NormFrac);
    end
  end

  // --------------------------------------------------------------------------
  // P14: round to Q16.16, clip to the 32-bit range, output register.
  // --------------------------------------------------------------------------
  logic signed [46:0] ur, vr;
  logic               uhi_c, ulo_c, vhi_c, vlo_c;
  logic signed [31:0] pixel_u_q, pixel_v_q;
  logic               behind_q, sat_q;

  assign ur    = 47'(rnd_haz(RndW'(us_q), 12));
  assign vr    = 47'(rnd_haz(RndW'(vs_q), 12));
  assign uhi_c = ur > 47'sd2147483647;
  assign ulo_c = ur < -47'sd2147483648;
  assign vhi_c = vr > 47'sd2147483647;
  assign vlo_c = vr < -47'sd2147483648;

  always_ff @(posedge clk_i) begin
    if (en) begin
      behind_q <= beh_q[12];
      if (beh_q[12]) begin
        pixel_u_q <= '0;
        pixel_v_q <= '0;
        sat_q     <= 1'b0;
      end else begin
        pixel_u_q <= uhi_c ? 32'sh7FFFFFFF : (ulo_c ? 32'sh80000000 : ur[31:0]);
        pixel_v_q <= vhi_c ? 32'sh7FFFFFFF : (vlo_c ? 32'sh80000000 : vr[31:0]);
        sat_q     <= clp_q[12] || uhi_c || ulo_c || vhi_c || vlo_c;
      end
    end
  end

  assign pixel_u_o       = pixel_u_q;
  assign pixel_v_o       = pixel_v_q;
  assign behind_camera_o = behind_q;
  assign saturated_o     = sat_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_behind_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && behind_camera_o) |->
      (pixel_u_o == '0 && pixel_v_o == '0 && !saturated_o))
    else $error("behind camera result has nonzero fields");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld_q[0])
    else $error("accepted item did not enter the pipeline");

  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(vld_q))
    else $error("pipeline moved while the result was stalled");

  a_stall_holds_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> ($stable(pixel_u_o) && $stable(pixel_v_o)))
    else $error("stalled result changed");

endmodule

// File: test/camera_point_projection_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// camera_point_projection_tb: self-checking bench for the point projector
// Streams world points through the block under several camera setups, with
// random idling on both sides, and checks every pixel item against a
// fixed-point projection computed here.
// ----------------------------------------------------------------------------
module camera_point_projection_tb;
  import cpp_pkg::*;

  localparam int unsigned WatchLimit = 20000;

  // A world point and the pixel item it should produce.
  typedef struct {
    logic signed [31:0] wx;
    logic signed [31:0] wy;
    logic signed [31:0] wz;
  } point_t;

  typedef struct {
    logic signed [31:0] u;
    logic signed [31:0] v;
    logic               behind;
    logic               sat;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_fire = 1'b0;
  logic signed [31:0] world_x = '0, world_y = '0, world_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] pixel_u, pixel_v;
  logic behind_camera, saturated;

  camera_point_projection dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .world_x_i(world_x), .world_y_i(world_y), .world_z_i(world_z),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .pixel_u_o(pixel_u), .pixel_v_o(pixel_v),
    .behind_camera_o(behind_camera), .saturated_o(saturated)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the camera setup, updated with every register write.
  logic [63:0] cam_regs [7];

  point_t pending_points[$];
  pixel_t expected_pixels[$];
  int     fail_count = 0;
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  int     hold_cycles = 0;
  int     idle_watch = 0;

  function automatic void add_point(point_t p);
    pending_points.insert(pending_points.size(), p);
  endfunction

  // Shift right rounding half away from zero (128-bit working width).
  function automatic logic signed [127:0] round_shift(logic signed [127:0] val, int sh);
    logic [127:0] mag;
    logic [127:0] half;
    half = 128'd1 << (sh - 1);
    if (val < 0) begin
      mag = -val;
      mag = (mag + half) >> sh;
      return -$signed(mag);
    end
    mag = val;
    mag = (mag + half) >> sh;
    return $signed(mag);
  endfunction

  // Depth division into Q.24, clamped to a magnitude of 4.0.
  function automatic logic signed [127:0] depth_divide(logic signed [127:0] num,
                                                       logic signed [127:0] den,
                                                       ref logic clip);
    logic [127:0] mag;
    logic [127:0] quo;
    logic signed [127:0] res;
    mag = (num < 0) ? -num : num;
    if (mag >= 4 * den) begin
      clip = 1'b1;
      res = 128'sd4 <<< 24;
    end else begin
      quo = (mag << 25) / den;
      res = $signed((quo + 1) >> 1);
    end
    return (num < 0) ? -res : res;
  endfunction

  function automatic logic signed [127:0] rot_entry(int row, int col);
    logic [17:0] raw;
    raw = cam_regs[row][col*18 +: 18];
    return $signed(raw);
  endfunction

  function automatic logic signed [127:0] camera_axis(int row, point_t p,
                                                     logic signed [31:0] t);
    return rot_entry(row, 0) * p.wx + rot_entry(row, 1) * p.wy
         + rot_entry(row, 2) * p.wz + (128'(t) <<< 12);
  endfunction

  function automatic logic signed [127:0] clip_pixel(logic signed [127:0] val,
                                                     ref logic clip);
    if (val > 128'sd2147483647) begin
      clip = 1'b1;
      return 128'sd2147483647;
    end
    if (val < -128'sd2147483648) begin
      clip = 1'b1;
      return -128'sd2147483648;
    end
    return val;
  endfunction

  function automatic pixel_t project_point(point_t p);
    pixel_t r;
    logic clip;
    logic signed [127:0] cx, cy, cz, xn, yn, x2, y2, xy, r2, r4, radial, xd, yd;
    logic signed [127:0] fx, fy, px, py, k1, k2, p1, p2;
    clip = 1'b0;
    cx = camera_axis(0, p, cam_regs[IDX_TRANS_XY][31:0]);
    cy = camera_axis(1, p, cam_regs[IDX_TRANS_XY][63:32]);
    cz = camera_axis(2, p, cam_regs[IDX_TRANS_Z][31:0]);
    r = '{u: '0, v: '0, behind: 1'b1, sat: 1'b0};
    if (cz <= 0) return r;
    fx = $signed({1'b0, cam_regs[IDX_INTRINSICS][15:0]});
    fy = $signed({1'b0, cam_regs[IDX_INTRINSICS][31:16]});
    px = $signed({1'b0, cam_regs[IDX_INTRINSICS][47:32]});
    py = $signed({1'b0, cam_regs[IDX_INTRINSICS][63:48]});
    k1 = $signed(cam_regs[IDX_DISTORTION][15:0]);
    k2 = $signed(cam_regs[IDX_DISTORTION][31:16]);
    p1 = $signed(cam_regs[IDX_DISTORTION][47:32]);
    p2 = $signed(cam_regs[IDX_DISTORTION][63:48]);
    xn = depth_divide(cx, cz, clip);
    yn = depth_divide(cy, cz, clip);
    x2 = round_shift(xn * xn, 24);
    y2 = round_shift(yn * yn, 24);
    xy = round_shift(xn * yn, 24);
    r2 = x2 + y2;
    r4 = round_shift(r2 * r2, 24);
    radial = (128'sd1 <<< 24) + round_shift(k1 * r2, 14) + round_shift(k2 * r4, 14);
    xd = round_shift(xn * radial, 24) + 2 * round_shift(p1 * xy, 14)
       + round_shift(p2 * (r2 + 2 * x2), 14);
    yd = round_shift(yn * radial, 24) + round_shift(p1 * (r2 + 2 * y2), 14)
       + 2 * round_shift(p2 * xy, 14);
    r.u = 32'(clip_pixel(round_shift(fx * xd + (px <<< 24), 12), clip));
    r.v = 32'(clip_pixel(round_shift(fy * yd + (py <<< 24), 12), clip));
    r.behind = 1'b0;
    r.sat = clip;
    return r;
  endfunction

  // Input handshake as seen at the rising edge.
  always @(posedge clk) begin
    in_fire <= rst_n && in_valid && !in_stall;
  end

  // Driver: offers the next point on the falling edge; the payload stays
  // put while the block stalls it.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_fire) begin
        expected_pixels.insert(expected_pixels.size(),
                               project_point(pending_points.pop_front()));
      end
      if ((!in_valid || in_fire) && pending_points.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        world_x <= pending_points[0].wx;
        world_y <= pending_points[0].wy;
        world_z <= pending_points[0].wz;
      end else if (!in_valid || in_fire) begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, or a long hold while hold_cycles runs down.
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles <= hold_cycles - 1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Monitor: checks each result item against the oldest expected pixel.
  always @(posedge clk) begin
    pixel_t exp_px;
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_watch <= 0;
    else idle_watch <= idle_watch + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (in_valid && !in_stall) begin
        // The item taken on this edge is queued by the driver on the next
        // falling edge; the pipeline is far too deep for it to be needed now.
      end
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected pixel item u=%0d v=%0d", $time, pixel_u, pixel_v);
        fail_count++;
      end else begin
        exp_px = expected_pixels.pop_front();
        if (pixel_u !== exp_px.u || pixel_v !== exp_px.v ||
            behind_camera !== exp_px.behind || saturated !== exp_px.sat) begin
          $display("%0t: mismatch expected u=%0d v=%0d behind=%0b sat=%0b",
                   $time, exp_px.u, exp_px.v, exp_px.behind, exp_px.sat);
          $display("%0t:          actual   u=%0d v=%0d behind=%0b sat=%0b",
                   $time, pixel_u, pixel_v, behind_camera, saturated);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (idle_watch >= WatchLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Register writes only happen with the pipeline empty.
  task automatic write_reg(cfg_idx_e idx, logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      IDX_ROT_ROW0, IDX_ROT_ROW1, IDX_ROT_ROW2: cam_regs[idx] = val & 64'h3F_FFFF_FFFF_FFFF;
      IDX_TRANS_Z: cam_regs[idx] = val & 64'hFFFF_FFFF;
      default: cam_regs[idx] = val;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_points.size() > 0 || in_valid || expected_pixels.size() > 0)
      @(negedge clk);
    repeat (Latency + 4) @(negedge clk);
  endtask

  function automatic logic [53:0] pack_row(int c0, int c1, int c2);
    return {18'(c2), 18'(c1), 18'(c0)};
  endfunction

  // Camera setup: mostly a mild pose and lens; extremes on request.
  task automatic load_camera(int style);
    case (style)
      0: begin  // identity pose, point pushed forward, mild lens distortion
        write_reg(IDX_ROT_ROW0, pack_row(65536, 0, 0));
        write_reg(IDX_ROT_ROW1, pack_row(0, 65536, 0));
        write_reg(IDX_ROT_ROW2, pack_row(0, 0, 65536));
        write_reg(IDX_TRANS_XY, {32'sd1048576, -32'sd2097152});
        write_reg(IDX_TRANS_Z, 32'sd10485760);
        write_reg(IDX_INTRINSICS, {16'd3840, 16'd5120, 16'd8000, 16'd8000});
        write_reg(IDX_DISTORTION, {16'sd40, -16'sd30, 16'sd1000, -16'sd2000});
      end
      1: begin  // extreme fields; rotation row 0 is all ones
        write_reg(IDX_ROT_ROW0, {54{1'b1}});
        write_reg(IDX_ROT_ROW1, pack_row(131071, -131072, 131071));
        write_reg(IDX_ROT_ROW2, pack_row(-131072, 131071, -131072));
        write_reg(IDX_TRANS_XY, {32'h8000_0000, 32'h7FFF_FFFF});
        write_reg(IDX_TRANS_Z, 32'h7FFF_FFFF);
        write_reg(IDX_INTRINSICS, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(IDX_DISTORTION, {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
      end
      default: begin  // random pose near identity, random lens
        write_reg(IDX_ROT_ROW0, pack_row(65536 - $urandom_range(8000),
                  $urandom_range(16000) - 8000, $urandom_range(16000) - 8000));
        write_reg(IDX_ROT_ROW1, pack_row($urandom_range(16000) - 8000,
                  65536 - $urandom_range(8000), $urandom_range(16000) - 8000));
        write_reg(IDX_ROT_ROW2, pack_row($urandom_range(16000) - 8000,
                  $urandom_range(16000) - 8000, 65536 - $urandom_range(8000)));
        write_reg(IDX_TRANS_XY, {32'($urandom_range(8000000)) - 32'sd4000000,
                                 32'($urandom_range(8000000)) - 32'sd4000000});
        write_reg(IDX_TRANS_Z, 32'($urandom_range(20000000, 2000000)));
        write_reg(IDX_INTRINSICS, {$urandom(), $urandom()});
        write_reg(IDX_DISTORTION, {$urandom(), $urandom()});
      end
    endcase
  endtask

  function automatic point_t random_point();
    point_t p;
    case ($urandom_range(9))
      0: p = '{$urandom(), $urandom(), $urandom()};  // anywhere in range
      1: p = '{$urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000,
               $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000,
               $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000};
      default: begin  // a point in front of the camera, moderate field of view
        p.wx = $signed($urandom_range(1600000)) - 800000;
        p.wy = $signed($urandom_range(1600000)) - 800000;
        p.wz = $signed($urandom_range(800000)) - 100000;
      end
    endcase
    return p;
  endfunction

  task automatic run_random(int count);
    repeat (count) add_point(random_point());
  endtask

  initial begin
    for (int i = 0; i < 7; i++) cam_regs[i] = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Reset setup: all zero, every point lands behind the camera.
    add_point('{32'sd65536, 32'sd65536, 32'sd65536});
    wait_drained();

    // Directed points: on axis, behind, wide angle, field extremes.
    load_camera(0);
    add_point('{32'sd0, 32'sd0, 32'sd0});
    add_point('{32'sd65536, -32'sd65536, 32'sd0});
    add_point('{32'sd0, 32'sd0, -32'sd20000000});      // behind
    add_point('{32'sd0, 32'sd0, -32'sd655360});        // depth zero
    add_point('{32'sd40000000, 32'sd0, 32'sd0});       // wide in x
    add_point('{32'sd0, -32'sd40000000, 32'sd0});      // wide in y
    add_point('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    add_point('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    add_point('{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
    add_point('{-32'sd1, -32'sd1, 32'sd1});
    wait_drained();
    load_camera(1);
    add_point('{32'sd0, 32'sd0, 32'sd0});
    add_point('{32'sd65536, 32'sd65536, -32'sd65536});
    add_point('{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000});
    add_point('{32'h8000_0000, 32'h7FFF_FFFF, 32'sd1});
    wait_drained();
    // Index beyond the register file is ignored by the block.
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= 3'd7;
    cfg_data <= '1;
    @(negedge clk);
    cfg_we <= 1'b0;

    // Random phase one: sender idles a quarter, receiver most of the time.
    send_idle_pct = 25;
    recv_idle_pct = 86;
    load_camera(2);
    run_random(350);
    wait_drained();

    // Random phase two: the other way round, with a long hold on the output
    // while points keep coming, so the pipeline fills and stalls its input.
    send_idle_pct = 86;
    recv_idle_pct = 25;
    load_camera(2);
    send_idle_pct = 0;
    hold_cycles = 200;
    run_random(150);
    while (hold_cycles > 0) @(negedge clk);
    send_idle_pct = 86;
    run_random(250);
    wait_drained();

    // Random phase three: no idling, extreme camera then random.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_camera(1);
    run_random(100);
    wait_drained();
    load_camera(2);
    run_random(300);
    wait_drained();

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
